// ----- rtl/mtg_pkg.sv -----
// Package for the MT19937 generator: array sizes, recurrence and tempering
// constants, the back-end state encoding and the tempering function.
// No dependencies; imported by mtg_back, the top module and the testbench.
package mtg_pkg;

  localparam int unsigned MtN   = 624;
  localparam int unsigned MtM   = 397;
  localparam int unsigned IdxW  = 10;

  localparam logic [IdxW-1:0] IdxUnseeded = IdxW'(MtN + 1);
  localparam logic [IdxW-1:0] IdxTwistDue = IdxW'(MtN);
  localparam logic [IdxW-1:0] IdxLast     = IdxW'(MtN - 1);
  localparam logic [IdxW-1:0] FarWrap     = IdxW'(MtN - MtM);
  localparam logic [IdxW-1:0] FarStep     = IdxW'(MtM);

  localparam logic [31:0] MatrixA   = 32'h9908_b0df;
  localparam logic [31:0] TemperB   = 32'h9d2c_5680;
  localparam logic [31:0] TemperC   = 32'hefc6_0000;
  localparam logic [31:0] LcgMult   = 32'd69069;
  localparam logic [31:0] SeedReset = 32'd4357;

  typedef enum logic [5:0] {
    ST_IDLE = 6'b000001,
    ST_SEED = 6'b000010,
    ST_TPRE = 6'b000100,
    ST_TRD  = 6'b001000,
    ST_TWR  = 6'b010000,
    ST_DRAW = 6'b100000
  } back_state_e;

  function automatic logic [31:0] temper(input logic [31:0] y);
    logic [31:0] t1;
    logic [31:0] t2;
    logic [31:0] t3;
    t1 = y ^ (y >> 11);
    t2 = t1 ^ ((t1 << 7) & TemperB);
    t3 = t2 ^ ((t2 << 15) & TemperC);
    return t3 ^ (t3 >> 18);
  endfunction

endpackage

// ----- rtl/mtg_front.sv -----
// Front end of the MT19937 generator: accepts request items, drops those
// with the request bit low, and counts pending draws in a short queue.
// Depends on mtg_pkg only by convention; no package items are needed here.
module mtg_front #(
  parameter int unsigned QueueDepth = 4
) (
  input  logic clk_i,
  input  logic rst_ni,
  input  logic in_valid_i,
  output logic in_stall_o,
  input  logic request_i,
  input  logic pop_i,
  output logic pending_o
);

  localparam int unsigned CntW = $clog2(QueueDepth + 1);

  logic [CntW-1:0] count_q, count_d;
  logic            full;
  logic            push;

  assign full       = (count_q == CntW'(QueueDepth));
  assign in_stall_o = full;
  // Every draw request is the same token, so the queue only holds a count.
  assign push       = in_valid_i && !full && request_i;
  assign pending_o  = (count_q != '0);

  always_comb begin
    count_d = count_q;
    case ({push, pop_i})
      2'b10:   count_d = count_q + 1'b1;
      2'b01:   count_d = count_q - 1'b1;
      default: count_d = count_q;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      count_q <= '0;
    end else begin
      count_q <= count_d;
    end
  end

endmodule

// ----- rtl/mtg_back.sv -----
// Back end of the MT19937 generator: seed register, 624-word state memory,
// LCG seeding sweep, in-place twist sweep, tempering and output register.
// Depends on mtg_pkg for constants, the state encoding and temper().
module mtg_back (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        pending_i,
  output logic        pop_o,
  input  logic        cfg_valid_i,
  output logic        cfg_ready_o,
  input  logic [31:0] seed_value_i,
  output logic        out_valid_o,
  input  logic        out_stall_i,
  output logic [31:0] random_word_o
);
  import mtg_pkg::*;

  back_state_e     state_q, state_d;
  logic [IdxW-1:0] idx_q, idx_d;
  logic [IdxW-1:0] k_q, k_d;
  logic            phase_q, phase_d;
  logic [15:0]     hi_q, hi_d;
  logic [31:0]     lcg_q, lcg_d;
  logic [31:0]     cur_q, cur_d;
  logic [31:0]     seed_q, seed_d;
  logic [31:0]     out_q, out_d;
  logic            out_valid_q, out_valid_d;

  logic [31:0]     state_mem_q [MtN];
  logic [31:0]     rd_a_q, rd_b_q;
  logic            rd_en;
  logic [IdxW-1:0] rd_a_addr, rd_b_addr;
  logic            wr_en;
  logic [IdxW-1:0] wr_addr;
  logic [31:0]     wr_data;

  logic [31:0]     lcg_next;
  logic [IdxW-1:0] nxt_addr, far_addr;
  logic [31:0]     twist_y, twist_v;
  logic            out_free;

  assign lcg_next = lcg_q * LcgMult + 32'd1;
  assign nxt_addr = (k_q == IdxLast) ? '0 : k_q + 1'b1;
  assign far_addr = (k_q < FarWrap) ? k_q + FarStep : k_q - FarWrap;

  // Upper bit of the old word k joined with the low bits of word k+1.
  assign twist_y = {cur_q[31], rd_a_q[30:0]};
  assign twist_v = rd_b_q ^ (twist_y >> 1) ^ (twist_y[0] ? MatrixA : 32'd0);

  assign out_free      = !out_valid_q || !out_stall_i;
  assign cfg_ready_o   = (state_q == ST_IDLE) && !pending_i;
  assign out_valid_o   = out_valid_q;
  assign random_word_o = out_q;

  always_comb begin
    state_d     = state_q;
    idx_d       = idx_q;
    k_d         = k_q;
    phase_d     = phase_q;
    hi_d        = hi_q;
    lcg_d       = lcg_q;
    cur_d       = cur_q;
    seed_d      = seed_q;
    out_d       = out_q;
    out_valid_d = out_valid_q && out_stall_i;
    rd_en       = 1'b0;
    rd_a_addr   = idx_q;
    rd_b_addr   = '0;
    wr_en       = 1'b0;
    wr_addr     = k_q;
    wr_data     = twist_v;
    pop_o       = 1'b0;

    if (cfg_valid_i && cfg_ready_o) begin
      seed_d = seed_value_i;
      idx_d  = IdxUnseeded;
    end

    unique case (state_q)
      ST_IDLE: begin
        if (pending_i) begin
          if (idx_q == IdxUnseeded) begin
            lcg_d   = seed_q;
            k_d     = '0;
            phase_d = 1'b0;
            state_d = ST_SEED;
          end else if (idx_q == IdxTwistDue) begin
            state_d = ST_TPRE;
          end else begin
            rd_en   = 1'b1;
            pop_o   = 1'b1;
            state_d = ST_DRAW;
          end
        end
      end
      ST_SEED: begin
        lcg_d = lcg_next;
        if (!phase_q) begin
          hi_d    = lcg_q[31:16];
          phase_d = 1'b1;
        end else begin
          wr_en   = 1'b1;
          wr_data = {hi_q, lcg_q[31:16]};
          phase_d = 1'b0;
          if (k_q == IdxLast) begin
            state_d = ST_TPRE;
          end else begin
            k_d = k_q + 1'b1;
          end
        end
      end
      ST_TPRE: begin
        rd_en     = 1'b1;
        rd_a_addr = '0;
        k_d       = '0;
        state_d   = ST_TRD;
      end
      ST_TRD: begin
        // rd_a_q still holds the old word k, read in ST_TPRE or the previous ST_TRD.
        cur_d     = rd_a_q;
        rd_en     = 1'b1;
        rd_a_addr = nxt_addr;
        rd_b_addr = far_addr;
        state_d   = ST_TWR;
      end
      ST_TWR: begin
        wr_en = 1'b1;
        if (k_q == IdxLast) begin
          idx_d   = '0;
          state_d = ST_IDLE;
        end else begin
          k_d     = k_q + 1'b1;
          state_d = ST_TRD;
        end
      end
      ST_DRAW: begin
        if (out_free) begin
          out_d       = temper(rd_a_q);
          out_valid_d = 1'b1;
          idx_d       = idx_q + 1'b1;
          state_d     = ST_IDLE;
        end
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i) begin
    if (wr_en) begin
      state_mem_q[wr_addr] <= wr_data;
    end
  end

  always_ff @(posedge clk_i) begin
    if (rd_en) begin
      rd_a_q <= state_mem_q[rd_a_addr];
      rd_b_q <= state_mem_q[rd_b_addr];
    end
  end

  always_ff @(posedge clk_i) begin
    k_q     <= k_d;
    phase_q <= phase_d;
    hi_q    <= hi_d;
    lcg_q   <= lcg_d;
    cur_q   <= cur_d;
    out_q   <= out_d;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      idx_q       <= IdxUnseeded;
      seed_q      <= SeedReset;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      idx_q       <= idx_d;
      seed_q      <= seed_d;
      out_valid_q <= out_valid_d;
    end
  end

endmodule

// ----- rtl/mersenne_twister_generator.sv -----
// MT19937 generator with 1998-style LCG seeding, one tempered word per request.
// Input items (request_i) enter on a valid/stall channel; items with the
// request bit low are taken and dropped. Each request bit set yields one
// random_word_o item on the output valid/stall channel, in order.
// A draw from a seeded state is one registered read of the state memory,
// then tempering into the output register.
// Every 624 draws the in-place twist runs first: after a priming read, a
// read on the memory's two read ports and a write per word. The first draw
// after reset or after a seed write also seeds the memory first with the
// LCG sweep (two multiplies per word) ahead of the twist.
// A queue of QueueDepth pending requests separates the input from the back
// end; in_stall_o rises only when it is full. The output register holds a
// finished word while out_stall_i is high, and the back end waits on it.
// Reset sets the seed to 4357 and marks the state unseeded; the memory
// itself is not cleared. cfg_ready_o is high when no draw is pending or
// under way; a seed write marks the generator unseeded again.
// Depends on mtg_pkg, mtg_front and mtg_back.
module mersenne_twister_generator #(
  parameter int unsigned QueueDepth = 4
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        in_valid_i,
  output logic        in_stall_o,
  input  logic        request_i,
  output logic        out_valid_o,
  input  logic        out_stall_i,
  output logic [31:0] random_word_o,
  input  logic        cfg_valid_i,
  output logic        cfg_ready_o,
  input  logic [31:0] seed_value_i
);
  import mtg_pkg::*;

  logic pending;
  logic pop;

  mtg_front #(
    .QueueDepth(QueueDepth)
  ) u_front (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_stall_o (in_stall_o),
    .request_i  (request_i),
    .pop_i      (pop),
    .pending_o  (pending)
  );

  mtg_back u_back (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .pending_i     (pending),
    .pop_o         (pop),
    .cfg_valid_i   (cfg_valid_i),
    .cfg_ready_o   (cfg_ready_o),
    .seed_value_i  (seed_value_i),
    .out_valid_o   (out_valid_o),
    .out_stall_i   (out_stall_i),
    .random_word_o (random_word_o)
  );

  // The back end never takes a draw that the queue does not hold.
  a_pop_needs_pending: assert property (@(posedge clk_i) disable iff (!rst_ni)
    pop |-> pending)
    else $error("draw popped from an empty queue");

  // A queued request with no draw taken leaves the queue non-empty.
  a_push_keeps_pending: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_valid_i && !in_stall_o && request_i && !pop) |=> pending)
    else $error("accepted request lost from the queue");

  // A draw holds the back end in ST_DRAW before the next draw can start.
  a_no_double_pop: assert property (@(posedge clk_i) disable iff (!rst_ni)
    pop |=> !pop)
    else $error("two draws started in consecutive cycles");

endmodule

// ----- verif/tb_mersenne_twister_generator.sv -----
// Self-checking testbench for mersenne_twister_generator: draws words under
// several seeds and compares each one with an MT19937 predictor kept here.
// Depends on mtg_pkg and the generator RTL.
module tb_mersenne_twister_generator;
  import mtg_pkg::*;

  localparam int unsigned CycleLimit = 400_000;
  localparam int unsigned IdlePct    = 26;
  localparam int unsigned HoldCycles = 400;

  logic        clk_i = 1'b0;
  logic        rst_ni = 1'b0;
  logic        in_valid = 1'b0;
  logic        in_stall_o;
  logic        request = 1'b0;
  logic        out_valid_o;
  logic        out_stall = 1'b0;
  logic [31:0] random_word_o;
  logic        cfg_valid = 1'b0;
  logic        cfg_ready_o;
  logic [31:0] seed_val = 32'd0;

  mersenne_twister_generator dut (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .in_valid_i   (in_valid),
    .in_stall_o   (in_stall_o),
    .request_i    (request),
    .out_valid_o  (out_valid_o),
    .out_stall_i  (out_stall),
    .random_word_o(random_word_o),
    .cfg_valid_i  (cfg_valid),
    .cfg_ready_o  (cfg_ready_o),
    .seed_value_i (seed_val)
  );

  always begin
    #4 clk_i = 1'b1;
    #4 clk_i = 1'b0;
  end

  // Predictor state: the generator's word array, read position and seed.
  logic [31:0]     mt_words [0:MtN-1];
  logic [IdxW-1:0] mt_pos = IdxUnseeded;
  logic [31:0]     mt_seed = SeedReset;

  bit          pending_req [$];
  logic [31:0] expected_words [$];
  logic        no_idle = 1'b0;
  logic        hold_arm = 1'b0;
  int unsigned hold_left = 0;
  int unsigned fail_count = 0;
  int unsigned words_checked = 0;
  int unsigned dropped_items = 0;
  int unsigned seed_writes = 0;
  int unsigned cycle_count = 0;

  function automatic logic [31:0] draw_tempered();
    logic [31:0] lcg;
    logic [31:0] w;
    logic [31:0] y;
    logic [31:0] v;
    if (mt_pos >= IdxTwistDue) begin
      if (mt_pos != IdxTwistDue) begin
        lcg = mt_seed;
        for (int k = 0; k < MtN; k++) begin
          w   = lcg & 32'hffff_0000;
          lcg = lcg * LcgMult + 32'd1;
          w   = w | (lcg >> 16);
          lcg = lcg * LcgMult + 32'd1;
          mt_words[k] = w;
        end
      end
      for (int k = 0; k < MtN; k++) begin
        y = {mt_words[k][31], mt_words[(k + 1) % MtN][30:0]};
        v = mt_words[(k + MtM) % MtN] ^ (y >> 1);
        if (y[0]) v = v ^ MatrixA;
        mt_words[k] = v;
      end
      mt_pos = '0;
    end
    y = mt_words[mt_pos];
    mt_pos = mt_pos + 1'b1;
    y = y ^ (y >> 11);
    y = y ^ ((y << 7) & TemperB);
    y = y ^ ((y << 15) & TemperC);
    return y ^ (y >> 18);
  endfunction

  // Driver: the valid stays up until the item is taken, then the next
  // pending item goes out unless this cycle is an idle one.
  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid <= 1'b0;
      request  <= 1'b0;
    end else if (!in_valid || !in_stall_o) begin
      if (in_valid && request) expected_words.push_back(draw_tempered());
      if (pending_req.size() != 0 && (no_idle || $urandom_range(99) >= IdlePct)) begin
        in_valid <= 1'b1;
        request  <= pending_req.pop_front();
      end else begin
        in_valid <= 1'b0;
      end
    end
  end

  always @(posedge clk_i) begin
    if (hold_arm) begin
      hold_left <= HoldCycles;
    end else if (hold_left != 0) begin
      hold_left <= hold_left - 1;
    end
  end

  // Monitor: each word taken is compared with the oldest prediction.
  always @(posedge clk_i or negedge rst_ni) begin
    logic [31:0] want;
    if (!rst_ni) begin
      out_stall <= 1'b0;
    end else begin
      if (out_valid_o && !out_stall) begin
        if (expected_words.size() == 0) begin
          $error("random_word: unexpected item %h", random_word_o);
          fail_count++;
        end else begin
          want = expected_words.pop_front();
          if (random_word_o !== want) begin
            $error("random_word: expected %h, actual %h", want, random_word_o);
            fail_count++;
          end
        end
        words_checked++;
      end
      out_stall <= (hold_left != 0) || (!no_idle && $urandom_range(99) < IdlePct);
    end
  end

  always @(posedge clk_i) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count == CycleLimit) begin
      $display("mersenne_twister_generator regression: fail");
      $finish;
    end
  end

  task automatic drain();
    while (pending_req.size() != 0 || in_valid || expected_words.size() != 0)
      @(posedge clk_i);
  endtask

  // Wait until every word is out, then leave the block quiet before
  // touching the seed.
  task automatic write_seed(input logic [31:0] value);
    drain();
    repeat (16) @(posedge clk_i);
    cfg_valid <= 1'b1;
    seed_val  <= value;
    do @(posedge clk_i); while (!cfg_ready_o);
    cfg_valid <= 1'b0;
    mt_seed = value;
    mt_pos  = IdxUnseeded;
    seed_writes++;
  endtask

  task automatic queue_draws(input int unsigned count);
    int unsigned done;
    done = 0;
    while (done < count) begin
      if ($urandom_range(99) < 15) begin
        pending_req.push_back(1'b0);
        dropped_items++;
      end else begin
        pending_req.push_back(1'b1);
        done++;
      end
    end
  endtask

  initial begin
    int unsigned lens [6];
    int unsigned mark;
    lens = '{700, 110, 560, 100, 80, 60};
    repeat (7) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // Directed: default seed, dropped items, extreme seeds, a reseed
    // in the middle of a sequence.
    pending_req = '{1'b1, 1'b0, 1'b1, 1'b1};
    dropped_items++;
    write_seed(32'h0000_0000);
    pending_req = '{1'b1, 1'b1};
    write_seed(32'hffff_ffff);
    pending_req = '{1'b1, 1'b0, 1'b1};
    dropped_items++;
    write_seed(32'h8000_0000);
    pending_req = '{1'b1};

    for (int p = 0; p < 6; p++) begin
      case (p)
        1:       write_seed(32'd1);
        3:       write_seed(32'h0000_ffff);
        5:       drain();
        default: write_seed($urandom);
      endcase
      no_idle = (p == 2);
      mark = words_checked;
      queue_draws(lens[p]);
      if (p == 3) begin
        // Let traffic start, then back the output up so the input stalls.
        while (words_checked < mark + 20) @(posedge clk_i);
        hold_arm <= 1'b1;
        @(posedge clk_i);
        hold_arm <= 1'b0;
      end
    end

    drain();
    no_idle = 1'b0;
    repeat (50) @(posedge clk_i);
    $display("Run covered %0d checked words under %0d seed writes,", words_checked,
             seed_writes);
    $display("including %0d dropped idle items and twists across long sequences.",
             dropped_items);
    if (fail_count == 0 && expected_words.size() == 0) begin
      $display("mersenne_twister_generator regression: pass");
    end else begin
      $display("mersenne_twister_generator regression: fail");
    end
    $finish;
  end

endmodule

// ----- mersenne_twister_generator.f -----
rtl/mtg_pkg.sv
rtl/mtg_front.sv
rtl/mtg_back.sv
rtl/mersenne_twister_generator.sv
verif/tb_mersenne_twister_generator.sv
